/* rtl/core/pts_pkg.sv */
// Shared types, codes and defaults for the priority task scheduler.
`default_nettype none
package pts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int ID_BITS_DEF   = 8;
  localparam int LEVELS_DEF    = 3;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_YIELD  = 3'd1;
  localparam logic [2:0] CMD_JOIN   = 3'd2;
  localparam logic [2:0] CMD_FINISH = 3'd3;
  localparam logic [2:0] CMD_START  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADPRIO = 2'd1;
  localparam logic [1:0] ST_NORUN   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] priority_req;
    logic [7:0] target_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] new_id;
    logic [7:0] running_id;
    logic       running_valid;
  } rsp_t;

  typedef struct packed {
    logic       capture;
    logic       status_load;
    logic [1:0] status;
    logic       create;
    logic       push_run;
    logic       block;
    logic       scan_start;
    logic       scan_read;
    logic       scan_step;
    logic       scan_end;
    logic       disp_pop;
    logic       disp_load;
    logic       disp_clear;
    logic       resp_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] command;
    logic       run_valid;
    logic       create_bad;
    logic       create_full;
    logic       push_full;
    logic       blk_full;
    logic       scan_done;
    logic       any_ready;
    logic       res_busy;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/pts_datapath.sv */
// Ready queues, blocked list, running task and result register.
`default_nettype none
module pts_datapath #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int ID_BITS   = pts_pkg::ID_BITS_DEF,
  parameter int LEVELS    = pts_pkg::LEVELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pts_pkg::req_t cmd_data,
  output pts_pkg::rsp_t res_data,
  output logic          res_valid,
  input  logic          res_ready,
  input  pts_pkg::ctl_t ctl,
  output pts_pkg::sts_t sts
);

  localparam int SB     = $clog2(MAX_TASKS);
  localparam int CB     = $clog2(MAX_TASKS + 1);
  localparam int LB     = $clog2(LEVELS);
  localparam int RDEPTH = LEVELS * MAX_TASKS;
  localparam int RA     = $clog2(RDEPTH);
  localparam int TOP    = (LEVELS - 1 < 2) ? LEVELS - 1 : 2;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [LB-1:0]      prio;
    logic [7:0]         target;
  } blk_t;

  pts_pkg::req_t      req;
  logic [1:0]         status;
  logic [ID_BITS-1:0] given;
  logic [ID_BITS-1:0] next_id;
  logic [ID_BITS-1:0] run_id;
  logic [LB-1:0]      run_prio;
  logic               run_valid;
  logic [SB-1:0]      head [LEVELS];
  logic [CB-1:0]      cnt  [LEVELS];
  logic [ID_BITS-1:0] rmem [RDEPTH];
  logic [ID_BITS-1:0] rmem_q;
  blk_t               bmem [MAX_TASKS];
  blk_t               brd;
  logic [CB-1:0]      blk_count;
  logic [CB-1:0]      scan_i;
  logic [CB-1:0]      scan_w;
  logic [LB-1:0]      disp_lv;

  logic [LB-1:0]      creq_lv;
  logic               prio_ok;
  logic               release_ok;
  logic               any_ready;
  logic [LB-1:0]      top_lv;
  logic               wr_en;
  logic [LB-1:0]      wr_lv;
  logic [ID_BITS-1:0] wr_id;
  logic [SB:0]        tsum;
  logic [SB-1:0]      tslot;
  logic [RA-1:0]      wr_addr;
  logic [RA-1:0]      rd_addr;
  logic               bw_en;
  logic [SB-1:0]      bw_addr;
  blk_t               bw_data;
  logic [15:0]        run_ext;
  logic [15:0]        given_ext;

  assign creq_lv    = LB'(req.priority_req);
  assign prio_ok    = (req.priority_req != 2'd0) && (32'(req.priority_req) <= 32'(TOP));
  assign release_ok = (16'(brd.target) == 16'(run_id)) && (cnt[brd.prio] != CB'(MAX_TASKS));

  always_comb begin
    any_ready = 1'b0;
    top_lv    = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt[l] != '0) begin
        any_ready = 1'b1;
        top_lv    = LB'(l);
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_lv = creq_lv;
    wr_id = next_id;
    if (ctl.create) begin
      wr_en = 1'b1;
    end else if (ctl.push_run) begin
      wr_en = 1'b1;
      wr_lv = run_prio;
      wr_id = run_id;
    end else if (ctl.scan_step && release_ok) begin
      wr_en = 1'b1;
      wr_lv = brd.prio;
      wr_id = brd.id;
    end
  end

  always_comb begin
    tsum = (SB + 1)'(head[wr_lv]) + (SB + 1)'(cnt[wr_lv]);
    if (32'(tsum) >= MAX_TASKS) begin
      tsum = tsum - (SB + 1)'(MAX_TASKS);
    end
    tslot = tsum[SB-1:0];
  end

  assign wr_addr = RA'(32'(wr_lv) * MAX_TASKS + 32'(tslot));
  assign rd_addr = RA'(32'(top_lv) * MAX_TASKS + 32'(head[top_lv]));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rmem[wr_addr] <= wr_id;
    end
    if (ctl.disp_pop) begin
      rmem_q <= rmem[rd_addr];
    end
  end

  always_comb begin
    bw_en   = 1'b0;
    bw_addr = blk_count[SB-1:0];
    bw_data = '{id: run_id, prio: run_prio, target: req.target_id};
    if (ctl.block) begin
      bw_en = 1'b1;
    end else if (ctl.scan_step && !release_ok) begin
      bw_en   = 1'b1;
      bw_addr = scan_w[SB-1:0];
      bw_data = brd;
    end
  end

  always_ff @(posedge clk) begin
    if (bw_en) begin
      bmem[bw_addr] <= bw_data;
    end
    if (ctl.scan_read) begin
      brd <= bmem[scan_i[SB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l] <= '0;
        cnt[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (wr_en && wr_lv == LB'(l)) begin
          cnt[l] <= cnt[l] + CB'(1);
        end else if (ctl.disp_pop && top_lv == LB'(l)) begin
          cnt[l]  <= cnt[l] - CB'(1);
          head[l] <= (head[l] == SB'(MAX_TASKS - 1)) ? '0 : head[l] + SB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req   <= cmd_data;
      given <= '0;
    end
    if (ctl.status_load) begin
      status <= ctl.status;
    end
    if (ctl.create) begin
      given <= next_id;
    end
    if (ctl.disp_pop) begin
      disp_lv <= top_lv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id   <= ID_BITS'(1);
      run_id    <= '0;
      run_prio  <= '0;
      run_valid <= 1'b0;
      blk_count <= '0;
      scan_i    <= '0;
      scan_w    <= '0;
    end else begin
      if (ctl.create) begin
        next_id <= next_id + ID_BITS'(1);
      end
      if (ctl.block) begin
        blk_count <= blk_count + CB'(1);
      end
      if (ctl.scan_start) begin
        scan_i <= '0;
        scan_w <= '0;
      end
      if (ctl.scan_step) begin
        scan_i <= scan_i + CB'(1);
        if (!release_ok) begin
          scan_w <= scan_w + CB'(1);
        end
      end
      if (ctl.scan_end) begin
        blk_count <= scan_w;
      end
      if (ctl.disp_load) begin
        run_id    <= rmem_q;
        run_prio  <= disp_lv;
        run_valid <= 1'b1;
      end else if (ctl.disp_clear) begin
        run_id    <= '0;
        run_prio  <= '0;
        run_valid <= 1'b0;
      end
    end
  end

  assign run_ext   = 16'(run_id);
  assign given_ext = 16'(given);

  always_ff @(posedge clk) begin
    if (ctl.resp_load) begin
      res_data.status        <= status;
      res_data.new_id        <= given_ext[7:0];
      res_data.running_id    <= run_valid ? run_ext[7:0] : 8'd0;
      res_data.running_valid <= run_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.resp_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign sts.command     = req.command;
  assign sts.run_valid   = run_valid;
  assign sts.create_bad  = !prio_ok;
  assign sts.create_full = (next_id == '0) || (cnt[creq_lv] == CB'(MAX_TASKS));
  assign sts.push_full   = cnt[run_prio] == CB'(MAX_TASKS);
  assign sts.blk_full    = blk_count == CB'(MAX_TASKS);
  assign sts.scan_done   = scan_i == blk_count;
  assign sts.any_ready   = any_ready;
  assign sts.res_busy    = res_valid && !res_ready;

endmodule
`default_nettype wire

/* rtl/core/pts_ctrl.sv */
// Command sequencer for the priority task scheduler.
`default_nettype none
module pts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pts_pkg::sts_t sts,
  output pts_pkg::ctl_t ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_DISP     = 3'd4;
  localparam logic [2:0] S_DISP_WR  = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign cmd_ready = state == S_IDLE;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.status_load = 1'b1;
        ctl.status      = pts_pkg::ST_OK;
        state_next      = S_RESP;
        case (sts.command)
          pts_pkg::CMD_CREATE: begin
            if (sts.create_bad) begin
              ctl.status = pts_pkg::ST_BADPRIO;
            end else if (sts.create_full) begin
              ctl.status = pts_pkg::ST_FULL;
            end else begin
              ctl.create = 1'b1;
            end
          end
          pts_pkg::CMD_YIELD: begin
            if (!sts.run_valid) begin
              ctl.status = pts_pkg::ST_NORUN;
            end else if (sts.push_full) begin
              ctl.status = pts_pkg::ST_FULL;
            end else begin
              ctl.push_run = 1'b1;
              state_next   = S_DISP;
            end
          end
          pts_pkg::CMD_JOIN: begin
            if (!sts.run_valid) begin
              ctl.status = pts_pkg::ST_NORUN;
            end else if (sts.blk_full) begin
              ctl.status = pts_pkg::ST_FULL;
            end else begin
              ctl.block  = 1'b1;
              state_next = S_DISP;
            end
          end
          pts_pkg::CMD_FINISH: begin
            if (!sts.run_valid) begin
              ctl.status = pts_pkg::ST_NORUN;
            end else begin
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN_RD;
            end
          end
          pts_pkg::CMD_START: begin
            if (!sts.run_valid) begin
              state_next = S_DISP;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (sts.scan_done) begin
          ctl.scan_end = 1'b1;
          state_next   = S_DISP;
        end else begin
          ctl.scan_read = 1'b1;
          state_next    = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        ctl.scan_step = 1'b1;
        state_next    = S_SCAN_RD;
      end
      S_DISP: begin
        if (sts.any_ready) begin
          ctl.disp_pop = 1'b1;
          state_next   = S_DISP_WR;
        end else begin
          ctl.disp_clear = 1'b1;
          state_next     = S_RESP;
        end
      end
      S_DISP_WR: begin
        ctl.disp_load = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (!sts.res_busy) begin
          ctl.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/priority_task_scheduler_with_join.sv */
// Top level of the strict-priority task scheduler with join.
//
// One command beat in (cmd_valid/cmd_ready, cmd_data) gives exactly one
// result beat out (res_valid/res_ready, res_data), in order.
// A command is taken only while the sequencer is idle; it then runs alone.
// Create, bad calls and start with a task running go from decode to the
// response step; yield, join and start dispatch the next ready task, or
// clear the running task when none is ready; finish first scans the
// blocked list, reading each entry and then checking and compacting it,
// and then dispatches. The next command is taken only after the last one
// has passed its response step, at the first edge that can also take the
// result beat.
// The result register lets the next command be taken while a result waits;
// a stalled receiver holds that command at its response step until the
// waiting beat leaves.
// Reset empties all ready queues and the blocked list, clears the running
// task and sets the next id to one; no clearing pass is needed.
`default_nettype none
module priority_task_scheduler_with_join #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int ID_BITS   = pts_pkg::ID_BITS_DEF,
  parameter int LEVELS    = pts_pkg::LEVELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pts_pkg::req_t cmd_data,
  output logic          res_valid,
  input  logic          res_ready,
  output pts_pkg::rsp_t res_data
);

  pts_pkg::ctl_t ctl;
  pts_pkg::sts_t sts;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  pts_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .ID_BITS   (ID_BITS),
    .LEVELS    (LEVELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_data),
    .res_data  (res_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
`default_nettype wire

/* rtl/core/pts_checker.sv */
// Port checker for the priority task scheduler, bound to the top level.
`default_nettype none
module pts_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          res_valid,
  input logic          res_ready,
  input pts_pkg::rsp_t res_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid && cmd_ready)
    else $error("not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in work");

  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.running_valid |-> res_data.running_id == 8'd0)
    else $error("running id set with no running task");

  a_new_id_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.new_id != 8'd0 |-> res_data.status == pts_pkg::ST_OK)
    else $error("new id given on a failed command");

endmodule

bind priority_task_scheduler_with_join pts_checker u_pts_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);
`default_nettype wire

/* tb/priority_task_scheduler_with_join_test.sv */
// Self-checking testbench for the strict-priority task scheduler with join.
module priority_task_scheduler_with_join_test;

  localparam int NTASK = pts_pkg::MAX_TASKS_DEF;
  localparam int NLEV  = pts_pkg::LEVELS_DEF;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  pts_pkg::req_t cmd_data;
  logic res_valid;
  logic res_ready;
  pts_pkg::rsp_t res_data;

  priority_task_scheduler_with_join DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  typedef struct {
    logic [7:0] id;
    logic [1:0] lvl;
    logic [7:0] tgt;
  } waiter_t;

  logic [7:0]    ready_q [NLEV][$];
  waiter_t       waiters [$];
  logic          sched_run;
  logic [7:0]    sched_id;
  logic [1:0]    sched_lvl;
  logic [7:0]    id_next;
  pts_pkg::rsp_t pending_rsp [$];
  int            errors;
  int            done_cnt;
  bit            quiet;

  function automatic bit queue_add(logic [1:0] lv, logic [7:0] id);
    if (lv >= NLEV || ready_q[lv].size() >= NTASK) return 1'b0;
    ready_q[lv].push_back(id);
    return 1'b1;
  endfunction

  function automatic void pick_next();
    for (int lv = 0; lv < NLEV; lv++) begin
      if (ready_q[lv].size() != 0) begin
        sched_id = ready_q[lv].pop_front();
        sched_lvl = 2'(lv);
        sched_run = 1'b1;
        return;
      end
    end
    sched_run = 1'b0;
    sched_id = '0;
    sched_lvl = '0;
  endfunction

  function automatic pts_pkg::rsp_t schedule(pts_pkg::req_t r);
    pts_pkg::rsp_t o;
    int i;
    o = '0;
    o.status = pts_pkg::ST_OK;
    case (r.command)
      pts_pkg::CMD_CREATE: begin
        if (r.priority_req < 1 || r.priority_req > 2) o.status = pts_pkg::ST_BADPRIO;
        else if (id_next == 0 || !queue_add(r.priority_req, id_next))
          o.status = pts_pkg::ST_FULL;
        else begin
          o.new_id = id_next;
          id_next = id_next + 8'd1;
        end
      end
      pts_pkg::CMD_YIELD: begin
        if (!sched_run) o.status = pts_pkg::ST_NORUN;
        else if (!queue_add(sched_lvl, sched_id)) o.status = pts_pkg::ST_FULL;
        else pick_next();
      end
      pts_pkg::CMD_JOIN: begin
        if (!sched_run) o.status = pts_pkg::ST_NORUN;
        else if (waiters.size() >= NTASK) o.status = pts_pkg::ST_FULL;
        else begin
          waiters.push_back('{sched_id, sched_lvl, r.target_id});
          pick_next();
        end
      end
      pts_pkg::CMD_FINISH: begin
        if (!sched_run) o.status = pts_pkg::ST_NORUN;
        else begin
          i = 0;
          while (i < waiters.size()) begin
            if (waiters[i].tgt == sched_id && queue_add(waiters[i].lvl, waiters[i].id))
              waiters.delete(i);
            else i++;
          end
          pick_next();
        end
      end
      pts_pkg::CMD_START: if (!sched_run) pick_next();
      default: ;
    endcase
    o.running_id = sched_run ? sched_id : 8'd0;
    o.running_valid = sched_run;
    return o;
  endfunction

  // hold valid across back-to-back beats; drop it only while idling
  task automatic send(pts_pkg::req_t r);
    while (!quiet && $urandom_range(99) < 18) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= r;
    pending_rsp.push_back(schedule(r));
    do @(posedge clk); while (!cmd_ready);
  endtask

  // directed rows: command, priority, target, check flag, status, new id, run id, run valid
  typedef struct {
    logic [2:0]    c;
    logic [1:0]    p;
    logic [7:0]    t;
    bit            chk;
    pts_pkg::rsp_t r;
  } row_t;

  row_t rows [] = '{
    '{pts_pkg::CMD_YIELD,  2'd0, 8'h00, 1, '{pts_pkg::ST_NORUN,   8'd0, 8'd0, 1'b0}},
    '{pts_pkg::CMD_JOIN,   2'd3, 8'hFF, 1, '{pts_pkg::ST_NORUN,   8'd0, 8'd0, 1'b0}},
    '{pts_pkg::CMD_FINISH, 2'd0, 8'h00, 1, '{pts_pkg::ST_NORUN,   8'd0, 8'd0, 1'b0}},
    '{pts_pkg::CMD_START,  2'd0, 8'h00, 1, '{pts_pkg::ST_OK,      8'd0, 8'd0, 1'b0}},
    '{pts_pkg::CMD_CREATE, 2'd0, 8'h00, 1, '{pts_pkg::ST_BADPRIO, 8'd0, 8'd0, 1'b0}},
    '{pts_pkg::CMD_CREATE, 2'd3, 8'hFF, 1, '{pts_pkg::ST_BADPRIO, 8'd0, 8'd0, 1'b0}},
    '{pts_pkg::CMD_CREATE, 2'd1, 8'h00, 1, '{pts_pkg::ST_OK,      8'd1, 8'd0, 1'b0}},
    '{pts_pkg::CMD_CREATE, 2'd2, 8'hFF, 1, '{pts_pkg::ST_OK,      8'd2, 8'd0, 1'b0}},
    '{pts_pkg::CMD_CREATE, 2'd1, 8'h00, 1, '{pts_pkg::ST_OK,      8'd3, 8'd0, 1'b0}},
    '{pts_pkg::CMD_START,  2'd0, 8'h00, 1, '{pts_pkg::ST_OK,      8'd0, 8'd1, 1'b1}},
    '{pts_pkg::CMD_START,  2'd0, 8'h00, 1, '{pts_pkg::ST_OK,      8'd0, 8'd1, 1'b1}},
    '{3'd5,                2'd0, 8'h00, 0, '0},
    '{3'd7,                2'd3, 8'hFF, 0, '0},
    '{pts_pkg::CMD_YIELD,  2'd0, 8'h00, 0, '0},
    '{pts_pkg::CMD_JOIN,   2'd0, 8'd3,  0, '0},
    '{pts_pkg::CMD_JOIN,   2'd0, 8'd1,  0, '0},
    '{pts_pkg::CMD_JOIN,   2'd0, 8'd200,0, '0},
    '{pts_pkg::CMD_FINISH, 2'd0, 8'h00, 0, '0},
    '{pts_pkg::CMD_FINISH, 2'd0, 8'h00, 0, '0},
    '{pts_pkg::CMD_CREATE, 2'd2, 8'h00, 0, '0},
    '{pts_pkg::CMD_START,  2'd0, 8'h00, 0, '0},
    '{pts_pkg::CMD_JOIN,   2'd0, 8'h00, 0, '0},
    '{pts_pkg::CMD_FINISH, 2'd0, 8'h00, 0, '0}
  };

  always @(posedge clk) begin
    if (rst) res_ready <= 1'b0;
    else res_ready <= quiet || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_data);
        errors++;
      end else begin
        if (res_data !== pending_rsp[0]) begin
          $display("%0t: expected %p, actual %p", $time, pending_rsp[0], res_data);
          errors++;
        end
        void'(pending_rsp.pop_front());
      end
      done_cnt++;
    end
  end

  function automatic pts_pkg::req_t rand_req();
    pts_pkg::req_t r;
    int k;
    k = $urandom_range(99);
    r.priority_req = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(2, 1));
    r.command = (k < 25) ? pts_pkg::CMD_CREATE : (k < 45) ? pts_pkg::CMD_YIELD :
                (k < 62) ? pts_pkg::CMD_JOIN : (k < 88) ? pts_pkg::CMD_FINISH :
                (k < 96) ? pts_pkg::CMD_START : 3'($urandom_range(7, 5));
    if ($urandom_range(3) == 0 || id_next < 4) r.target_id = 8'($urandom);
    else r.target_id = 8'($urandom_range(id_next - 1, (id_next > 20) ? id_next - 20 : 1));
    return r;
  endfunction

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_data = '0;
    res_ready = 1'b0;
    errors = 0;
    done_cnt = 0;
    quiet = 0;
    sched_run = 0;
    sched_id = 0;
    sched_lvl = 0;
    id_next = 8'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send('{rows[i].c, rows[i].p, rows[i].t});
      if (rows[i].chk) pending_rsp[$] = rows[i].r;
    end
    for (int n = 0; n < 1650; n++) begin
      quiet = (n >= 400 && n < 600);
      if (n == 800 || n == 1200) begin
        cmd_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(posedge clk);
      end
      send(rand_req());
    end
    quiet = 0;
    cmd_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
